// ===== design/bpa_pkg.sv =====
package bpa_pkg;

  localparam int MAX_PAGES = 16384;
  localparam int CAP_LG    = $clog2(MAX_PAGES + 1) - 1;
  localparam int POOL_MAX  = 1 << CAP_LG;
  localparam int NODES     = 2 * POOL_MAX - 1;
  localparam int NODE_AW   = $clog2(NODES);
  localparam int VAL_W     = CAP_LG + 1;

  localparam int OP_W    = 2;
  localparam int COUNT_W = 15;
  localparam int OFFS_W  = 14;
  localparam int FREE_W  = 15;
  localparam int CFG_W   = 20;
  localparam int LG_W    = $clog2(COUNT_W + 1);
  localparam int SZ_W    = 17;

  localparam logic [CFG_W-1:0] POOL_PAGES_RST = CFG_W'(16384);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic rb_init;
    logic fill;
    logic rd_root;
    logic down_first;
    logic down_step;
    logic free_init;
    logic leaf;
    logic up;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad;
    logic rb_empty;
    logic root_ok;
    logic zero_steps;
    logic last_down;
    logic fill_last;
    logic at_root;
    logic par_root;
  } stat_t;

  function automatic logic [LG_W-1:0] ceil_lg(input logic [COUNT_W-1:0] x);
    logic [LG_W-1:0] r;
    r = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (SZ_W'(x) > (SZ_W'(1) << i)) r = LG_W'(i + 1);
    end
    return r;
  endfunction

endpackage

// ===== design/bpa_ctrl.sv =====
module bpa_ctrl import bpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_FILL, S_ROOT_CHK, S_DOWN, S_LEAF, S_UP, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_REBUILD: begin
            cmd.rb_init = 1'b1;
            state_nxt   = stat.rb_empty ? S_FINISH : S_FILL;
          end
          OP_ALLOC: begin
            if (stat.bad) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.rd_root = 1'b1;
              state_nxt   = S_ROOT_CHK;
            end
          end
          OP_FREE: begin
            if (stat.bad) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.free_init = 1'b1;
              state_nxt     = S_LEAF;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) state_nxt = S_FINISH;
      end
      S_ROOT_CHK: begin
        if (!stat.root_ok) begin
          state_nxt = S_FINISH;
        end else if (stat.zero_steps) begin
          state_nxt = S_LEAF;
        end else begin
          cmd.down_first = 1'b1;
          state_nxt      = S_DOWN;
        end
      end
      S_DOWN: begin
        cmd.down_step = 1'b1;
        if (stat.last_down) state_nxt = S_LEAF;
      end
      S_LEAF: begin
        cmd.leaf  = 1'b1;
        state_nxt = stat.at_root ? S_FINISH : S_UP;
      end
      S_UP: begin
        cmd.up = 1'b1;
        if (stat.par_root) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DECODE)
    else $error("accepted word did not enter decode");

  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP |-> !stat.at_root)
    else $error("merge walk above the root");

  a_down_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DOWN |-> !stat.zero_steps)
    else $error("descent without levels left");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result word raised outside finish");

endmodule

// ===== design/bpa_dp.sv =====
module bpa_dp import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [COUNT_W-1:0] in_page_count,
  input  logic [OFFS_W-1:0]  in_page_offset,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               out_ok,
  output logic [OFFS_W-1:0]  out_block_offset,
  output logic [FREE_W-1:0]  out_pages_left
);

  logic [VAL_W-1:0] mem [NODES];
  logic [VAL_W-1:0] rdata_r;
  logic             we;
  logic [NODE_AW-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata;

  logic [CFG_W-1:0]   pool_pages_r;
  logic [LG_W-1:0]    pool_lg_r;
  logic               pool_empty_r;
  logic [FREE_W-1:0]  free_cnt_r;
  op_t                op_r;
  logic [LG_W-1:0]    need_lg_r;
  logic [OFFS_W-1:0]  offs_r;
  logic [NODE_AW-1:0] idx_r;
  logic [LG_W-1:0]    steps_r;
  logic [VAL_W-1:0]   cur_r;
  logic [SZ_W-1:0]    up_size_r;
  logic               ok_r;
  logic [OFFS_W-1:0]  blk_r;
  logic               res_ok_r;
  logic [OFFS_W-1:0]  res_blk_r;
  logic [FREE_W-1:0]  res_free_r;

  logic [SZ_W-1:0]    need, pool_sz, sum, leaf_val, blk_calc, free_sum;
  logic [4:0]         cfg_lg;
  logic [LG_W-1:0]    rb_lg;
  logic               bad_a, bad_f;
  logic [NODE_AW-1:0] nidx, parent, sib_idx, sib_par;
  logic [VAL_W-1:0]   up_val, mx;
  logic [NODE_AW:0]   idx_p1, idx_p2;

  assign need    = SZ_W'(1) << need_lg_r;
  assign pool_sz = pool_empty_r ? '0 : SZ_W'(1) << pool_lg_r;
  assign bad_a   = pool_empty_r || (need_lg_r > pool_lg_r);
  assign bad_f   = bad_a || ((SZ_W'(offs_r) & (need - SZ_W'(1))) != '0) ||
                   (SZ_W'(offs_r) + need > pool_sz);

  always_comb begin
    cfg_lg = '0;
    for (int i = 0; i < CFG_W; i++) begin
      if (pool_pages_r[i]) cfg_lg = 5'(i);
    end
    rb_lg = (cfg_lg > 5'(CAP_LG)) ? LG_W'(CAP_LG) : cfg_lg[LG_W-1:0];
  end

  assign nidx    = ({1'b0, rdata_r} >= need[VAL_W:0]) ?
                   NODE_AW'((idx_r << 1) + 1) : NODE_AW'((idx_r << 1) + 2);
  assign parent  = NODE_AW'((idx_r - NODE_AW'(1)) >> 1);
  assign sib_idx = idx_r[0] ? idx_r + NODE_AW'(1) : idx_r - NODE_AW'(1);
  assign sib_par = parent[0] ? parent + NODE_AW'(1) : parent - NODE_AW'(1);
  assign sum     = SZ_W'(cur_r) + SZ_W'(rdata_r);
  assign mx      = (cur_r > rdata_r) ? cur_r : rdata_r;
  assign up_val  = (op_r == OP_FREE && sum == up_size_r) ? up_size_r[VAL_W-1:0] : mx;
  assign leaf_val = (op_r == OP_FREE) ? need : '0;
  assign blk_calc = ((SZ_W'(idx_r) + SZ_W'(1)) << need_lg_r) - pool_sz;
  assign free_sum = SZ_W'(free_cnt_r) + need;
  assign idx_p1   = {1'b0, idx_r} + (NODE_AW+1)'(1);
  assign idx_p2   = {1'b0, idx_r} + (NODE_AW+1)'(2);

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = cur_r;
    raddr = '0;
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.leaf) begin
      we    = 1'b1;
      wdata = leaf_val[VAL_W-1:0];
      raddr = sib_idx;
    end else if (cmd.up) begin
      we    = 1'b1;
      waddr = parent;
      wdata = up_val;
      raddr = sib_par;
    end else if (cmd.down_first) begin
      raddr = NODE_AW'(1);
    end else if (cmd.down_step) begin
      raddr = NODE_AW'((nidx << 1) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_pages_r <= POOL_PAGES_RST;
      pool_lg_r    <= '0;
      pool_empty_r <= 1'b1;
      free_cnt_r   <= '0;
    end else begin
      if (cfg_we) pool_pages_r <= cfg_wdata;
      if (cmd.rb_init) begin
        pool_empty_r <= (pool_pages_r == '0);
        pool_lg_r    <= rb_lg;
        free_cnt_r   <= (pool_pages_r == '0) ? '0 : FREE_W'(1) << rb_lg;
      end
      if (cmd.leaf) begin
        if (op_r == OP_FREE) begin
          free_cnt_r <= (free_sum > pool_sz) ? pool_sz[FREE_W-1:0] : free_sum[FREE_W-1:0];
        end else begin
          free_cnt_r <= (SZ_W'(free_cnt_r) >= need) ?
                        free_cnt_r - need[FREE_W-1:0] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_operation);
      need_lg_r <= ceil_lg(in_page_count);
      offs_r    <= in_page_offset;
      ok_r      <= 1'b0;
      blk_r     <= '0;
    end
    if (cmd.rb_init) begin
      idx_r <= '0;
      cur_r <= VAL_W'(1) << rb_lg;
      ok_r  <= (pool_pages_r != '0);
    end
    if (cmd.fill) begin
      idx_r <= idx_p1[NODE_AW-1:0];
      if ((idx_p1 & idx_p2) == '0) cur_r <= cur_r >> 1;
    end
    if (cmd.rd_root) begin
      idx_r   <= '0;
      steps_r <= pool_lg_r - need_lg_r;
    end
    if (cmd.down_step) begin
      steps_r <= steps_r - LG_W'(1);
      idx_r   <= nidx;
    end
    if (cmd.free_init) begin
      idx_r <= NODE_AW'(((SZ_W'(offs_r) + pool_sz) >> need_lg_r) - SZ_W'(1));
    end
    if (cmd.leaf) begin
      cur_r     <= leaf_val[VAL_W-1:0];
      up_size_r <= need << 1;
      ok_r      <= 1'b1;
      if (op_r == OP_ALLOC) blk_r <= blk_calc[OFFS_W-1:0];
    end
    if (cmd.up) begin
      idx_r     <= parent;
      cur_r     <= up_val;
      up_size_r <= up_size_r << 1;
    end
    if (cmd.finish) begin
      res_ok_r   <= ok_r;
      res_blk_r  <= blk_r;
      res_free_r <= free_cnt_r;
    end
  end

  assign stat.op         = op_r;
  assign stat.bad        = (op_r == OP_ALLOC) ? bad_a : (op_r == OP_FREE) ? bad_f : 1'b1;
  assign stat.rb_empty   = (pool_pages_r == '0);
  assign stat.root_ok    = ({1'b0, rdata_r} >= need[VAL_W:0]);
  assign stat.zero_steps = (steps_r == '0);
  assign stat.last_down  = (steps_r == LG_W'(1));
  assign stat.fill_last  = (SZ_W'(idx_r) == (pool_sz << 1) - SZ_W'(2));
  assign stat.at_root    = (idx_r == '0);
  assign stat.par_root   = (parent == '0);

  assign out_ok           = res_ok_r;
  assign out_block_offset = res_blk_r;
  assign out_pages_left   = res_free_r;

endmodule

// ===== design/buddy_page_allocator.sv =====
// Buddy page allocator over a power-of-two pool of pages.
// Input channel (in_valid/in_stall) takes one word: in_operation selects
// allocate, free or rebuild; in_page_count and in_page_offset qualify it.
// Result channel (out_valid/out_stall) returns one word per input word:
// out_ok, out_block_offset of an allocation and out_pages_left afterwards.
// cfg_we/cfg_wdata write the pool page count; it is used by the next rebuild.
// An allocate walks one tree level per cycle down and one per cycle up;
// a free only walks up, and a rebuild writes every tree node once.
// Rejected items, and allocations for which no free block is large enough,
// skip the tree walk and go straight to the result.
// One word is worked on at a time; the next is taken once the result sits
// in the output register, even while the receiver stalls it.
// A stalled result holds, and a finished item waits for the register to empty.
// After reset the pool is empty and every allocate and free fails until a
// rebuild; the configured page count resets to 16384.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [COUNT_W-1:0] in_page_count,
  input  logic [OFFS_W-1:0]  in_page_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [OFFS_W-1:0]  out_block_offset,
  output logic [FREE_W-1:0]  out_pages_left
);

  cmd_t  cmd;
  stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_page_count    (in_page_count),
    .in_page_offset   (in_page_offset),
    .cmd              (cmd),
    .stat             (stat),
    .out_ok           (out_ok),
    .out_block_offset (out_block_offset),
    .out_pages_left   (out_pages_left)
  );

endmodule
